>>> rtl/core/mt19937_random_generator_top_macros.svh
// assertion macros for the mt19937 generator checker
// no dependencies; included by the checker file
`ifndef MT19937_RANDOM_GENERATOR_TOP_MACROS_SVH
`define MT19937_RANDOM_GENERATOR_TOP_MACROS_SVH

// next-cycle implication, off during reset
`define MTRG_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("mtrg checker: next-cycle rule violated");

// next-cycle implication that also holds while reset is applied
`define MTRG_ASSERT_ALWAYS(label, clk, lhs, rhs) \
    label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
        else $error("mtrg checker: reset rule violated");

`endif

>>> rtl/core/mtrg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tempering function of the mt19937 generator
// no dependencies
package mtrg_pkg;

    localparam int unsigned STATE_WORDS = 624;
    localparam int unsigned IDX_W       = 10;
    localparam logic [IDX_W-1:0] IDX_LAST    = 10'd623;
    localparam logic [IDX_W-1:0] IDX_FULL    = 10'd624;
    localparam logic [IDX_W-1:0] TWIST_SHIFT = 10'd397;
    localparam logic [IDX_W-1:0] TWIST_WRAP  = 10'd227;

    localparam logic [31:0] SEED_MULT    = 32'h6C078965;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
    localparam logic [31:0] UPPER_BIT    = 32'h80000000;
    localparam logic [31:0] LOWER_BITS   = 32'h7FFFFFFF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC60000;

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_SEED = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] seed;
        logic [31:0] limit;
    } t_item;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SEED,
        BK_TW_PRIME,
        BK_TW_LOAD,
        BK_TW_RD,
        BK_TW_WR,
        BK_DR_RD,
        BK_DR_TEMP,
        BK_DIV,
        BK_OUT
    } t_bk_state;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> rtl/core/mtrg_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces of the mt19937 generator
// depends on nothing
interface mtrg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] seed;
    logic [31:0] limit;
    modport source (output valid, req_type, seed, limit, input ready);
    modport sink   (input valid, req_type, seed, limit, output ready);
endinterface

interface mtrg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_value;
    modport source (output valid, random_value, input ready);
    modport sink   (input valid, random_value, output ready);
endinterface

>>> rtl/core/mtrg_front.sv
`timescale 1ns / 1ps
// front stage: accepts request words, decodes the request type, registers them
// depends on mtrg_pkg
module mtrg_front
    import mtrg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_req_type,
    input  logic [31:0] i_seed,
    input  logic [31:0] i_limit,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    logic  r_valid, n_valid;
    t_item r_item, n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid      = 1'b1;
            n_item.op    = i_req_type ? OP_SEED : OP_DRAW;
            n_item.seed  = i_seed;
            // a reseed ignores the limit, draws ignore the seed
            n_item.limit = i_req_type ? 32'd0 : i_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end
endmodule

>>> rtl/core/mtrg_queue.sv
`timescale 1ns / 1ps
// short request queue between front and back
// depends on mtrg_pkg
module mtrg_queue
    import mtrg_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule

>>> rtl/core/mtrg_back.sv
`timescale 1ns / 1ps
// back end: state memory, seeding, twist, tempering, serial modulo, output register
// depends on mtrg_pkg
module mtrg_back
    import mtrg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_pop,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output logic [31:0] o_value
);
    logic [31:0] r_mem [STATE_WORDS];
    logic [31:0] r_rd_a, r_rd_b;
    logic [IDX_W-1:0] w_addr_a, w_addr_b, w_wr_addr;
    logic [31:0] w_wr_data;
    logic        w_we;

    t_bk_state        r_state, n_state;
    t_item            r_item, n_item;
    logic [IDX_W-1:0] r_index, n_index;
    logic [IDX_W-1:0] r_i, n_i;
    logic [31:0]      r_prev, n_prev;
    logic [31:0]      r_word, n_word;
    logic [31:0]      r_rem, n_rem;
    logic [31:0]      r_dvd, n_dvd;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out, n_out;

    logic [31:0]      w_mix, w_y, w_tw, w_tmp;
    logic [32:0]      w_sh, w_sub;
    logic [IDX_W-1:0] w_next, w_far;

    assign o_valid = r_out_valid;
    assign o_value = r_out;

    assign w_next = (r_i == IDX_LAST) ? '0 : r_i + 1'b1;
    assign w_far  = (r_i < TWIST_WRAP) ? r_i + TWIST_SHIFT : r_i - TWIST_WRAP;
    assign w_mix  = SEED_MULT * (r_prev ^ (r_prev >> 30)) + {22'd0, r_i};
    assign w_y    = (r_prev & UPPER_BIT) | (r_rd_a & LOWER_BITS);
    assign w_tw   = r_rd_b ^ (w_y >> 1) ^ (w_y[0] ? TWIST_MATRIX : 32'd0);
    assign w_tmp  = temper(r_rd_a);
    assign w_sh   = {r_rem, r_dvd[31]};
    assign w_sub  = w_sh - {1'b0, r_item.limit};

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_index     = r_index;
        n_i         = r_i;
        n_prev      = r_prev;
        n_word      = r_word;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_addr_a    = r_index;
        w_addr_b    = w_far;
        w_we        = 1'b0;
        w_wr_addr   = r_i;
        w_wr_data   = w_tw;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_i    = '0;
                    if (i_item.op == OP_SEED) begin
                        n_state = BK_SEED;
                    end else if (r_index >= IDX_FULL) begin
                        n_state = BK_TW_PRIME;
                    end else begin
                        n_state = BK_DR_RD;
                    end
                end
            end
            BK_SEED: begin
                w_we      = 1'b1;
                w_wr_data = (r_i == '0) ? r_item.seed : w_mix;
                n_prev    = w_wr_data;
                if (r_i == IDX_LAST) begin
                    n_index = IDX_FULL;
                    n_state = BK_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            BK_TW_PRIME: begin
                w_addr_a = '0;
                n_state  = BK_TW_LOAD;
            end
            BK_TW_LOAD: begin
                n_prev  = r_rd_a;
                n_state = BK_TW_RD;
            end
            BK_TW_RD: begin
                w_addr_a = w_next;
                n_state  = BK_TW_WR;
            end
            BK_TW_WR: begin
                // word i+1 read here is still untwisted, it becomes the next upper word
                w_we   = 1'b1;
                n_prev = r_rd_a;
                if (r_i == IDX_LAST) begin
                    n_index = '0;
                    n_state = BK_DR_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = BK_TW_RD;
                end
            end
            BK_DR_RD: begin
                n_state = BK_DR_TEMP;
            end
            BK_DR_TEMP: begin
                n_index = r_index + 1'b1;
                n_word  = w_tmp;
                n_rem   = '0;
                n_dvd   = w_tmp;
                n_cnt   = '0;
                n_state = (r_item.limit == '0) ? BK_OUT : BK_DIV;
            end
            BK_DIV: begin
                // restoring division, one quotient bit a cycle, remainder kept
                n_rem = w_sub[32] ? w_sh[31:0] : w_sub[31:0];
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_word  = n_rem;
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_word;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_index     <= IDX_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_index     <= n_index;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_i    <= n_i;
        r_prev <= n_prev;
        r_word <= n_word;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end
endmodule

>>> rtl/core/mt19937_random_generator_top.sv
`timescale 1ns / 1ps
// reseed: the back end pops the item, then writes one state word per cycle
// draw: the back end reads and tempers the state word, reduces it by a serial restoring
// remainder when the limit is nonzero, then registers the result word; a draw that finds
// the index at 624 first twists the state: a priming read, then a read and a write per word
// throughput: one item at a time in the back end; front register and a 2-word queue keep taking
// reset: control, queue and read index (624) clear; state memory is undefined until reseed
module mt19937_random_generator_top
    import mtrg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mtrg_req_if.sink   i_req,
    mtrg_rsp_if.source o_rsp
);
    // front register to queue
    logic  w_f_valid, w_f_ready;
    t_item w_f_item;
    // queue to back end
    logic  w_q_valid, w_q_pop;
    t_item w_q_item;

    // front: decode request word
    mtrg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .o_ready    (i_req.ready),
        .i_req_type (i_req.req_type),
        .i_seed     (i_req.seed),
        .i_limit    (i_req.limit),
        .o_valid    (w_f_valid),
        .i_ready    (w_f_ready),
        .o_item     (w_f_item)
    );

    // decoupling queue
    mtrg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    // back end: memory sequencer and output word register
    mtrg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_pop   (w_q_pop),
        .i_item  (w_q_item),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_value (o_rsp.random_value)
    );
endmodule

>>> rtl/core/mtrg_checker.sv
`timescale 1ns / 1ps
// port-level checker for the mt19937 generator, bound to the top level
// depends on mt19937_random_generator_top_macros.svh
`include "mt19937_random_generator_top_macros.svh"
module mtrg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value
);
    // output word held while stalled
    `MTRG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `MTRG_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_value))
    // no result right after reset
    `MTRG_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !i_out_valid)
    // an offered request word stays offered until it is taken
    `MTRG_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !i_in_ready, i_in_valid)
endmodule

bind mt19937_random_generator_top mtrg_checker u_mtrg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_value (o_rsp.random_value)
);

>>> dv/mt19937_random_generator_checker.sv
`timescale 1ns / 1ps
// checker for the mt19937 generator: watches both channels, predicts each drawn word
// depends on mtrg_pkg and the channel interfaces in mtrg_if.sv
module mt19937_random_generator_checker
    import mtrg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mtrg_req_if  i_req,
    mtrg_rsp_if  i_rsp,
    output int   o_errors,
    output int   o_pending
);

    logic [31:0] mt_words [STATE_WORDS];
    int unsigned mt_index;
    logic [31:0] draw_q [$];

    function automatic logic [31:0] mix_word(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    task automatic model_reseed(input logic [31:0] s);
        mt_words[0] = s;
        for (int i = 1; i < STATE_WORDS; i++)
            mt_words[i] = SEED_MULT * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + i;
        mt_index = STATE_WORDS;
    endtask

    task automatic model_twist();
        logic [31:0] y;
        for (int i = 0; i < STATE_WORDS; i++) begin
            y = (mt_words[i] & UPPER_BIT) | (mt_words[(i+1) % STATE_WORDS] & LOWER_BITS);
            mt_words[i] = mt_words[(i+397) % STATE_WORDS] ^ (y >> 1)
                        ^ (y[0] ? TWIST_MATRIX : 32'h0);
        end
        mt_index = 0;
    endtask

    task automatic model_draw(input logic [31:0] lim);
        logic [31:0] w;
        if (mt_index >= STATE_WORDS) model_twist();
        w = mix_word(mt_words[mt_index]);
        mt_index++;
        if (lim != 0) w = w % lim;
        draw_q.push_back(w);
    endtask

    initial begin
        o_errors = 0;
        mt_index = STATE_WORDS;
        foreach (mt_words[i]) mt_words[i] = '0;
    end

    assign o_pending = draw_q.size();

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                if (t_op'(i_req.req_type) == OP_SEED) model_reseed(i_req.seed);
                else model_draw(i_req.limit);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (draw_q.size() == 0) begin
                    $error("random_value: unexpected word %h", i_rsp.random_value);
                    o_errors <= o_errors + 1;
                end else begin
                    if (i_rsp.random_value !== draw_q[0]) begin
                        $error("random_value: expected %h actual %h",
                               draw_q[0], i_rsp.random_value);
                        o_errors <= o_errors + 1;
                    end
                    void'(draw_q.pop_front());
                end
            end
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// top of the mt19937 generator testbench: clock, reset, request stimulus and verdict
// depends on mtrg_pkg, mtrg_if.sv, the generator rtl and the checker module
module tb;
    import mtrg_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   send_idle;   // percent of cycles the sender holds off
    int   recv_idle;   // percent of cycles the receiver stalls

    mtrg_req_if req_ch ();
    mtrg_rsp_if rsp_ch ();

    mt19937_random_generator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mt19937_random_generator_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver stalls at random; ready is held high when idling is off
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // one request word, with random idle cycles before it is offered
    task automatic send_word(input t_op op, input logic [31:0] s, input logic [31:0] lim);
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.seed     <= s;
        req_ch.limit    <= lim;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic go_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // limit mix: zero, small, power-of-two, full range
    function automatic logic [31:0] pick_limit();
        case ($urandom_range(4))
            0: return 32'h0;
            1: return $urandom_range(1, 20);
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = OP_DRAW;
        req_ch.seed     = '0;
        req_ch.limit    = '0;
        rsp_ch.ready    = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reseed first so the state is defined, then field extremes
        send_word(OP_SEED, 32'd5489, 32'h0);
        send_word(OP_DRAW, 32'h0, 32'h0);
        send_word(OP_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_DRAW, 32'h0, 32'h1);
        send_word(OP_DRAW, 32'h0, 32'h8000_0000);
        send_word(OP_DRAW, 32'h0, 32'h7);
        send_word(OP_SEED, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_DRAW, 32'h0, 32'h0);
        send_word(OP_SEED, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_DRAW, 32'h0, 32'h0);
        send_word(OP_DRAW, 32'h0, 32'hFFFF_FFFE);
        // back-to-back reseeds with no draw in between
        send_word(OP_SEED, 32'h1234_5678, 32'h0);
        send_word(OP_SEED, 32'hA5A5_5A5A, 32'h0);
        send_word(OP_DRAW, 32'h0, 32'h3);
        go_idle();

        // hold off until every outstanding word has come back
        while (pending != 0) @(posedge i_clk);

        // random: three idling phases of 612 request words each, mostly draws with an occasional reseed
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 38 : (ph == 1) ? 78 : 0;
            recv_idle = (ph == 0) ? 78 : (ph == 1) ? 38 : 0;
            for (int n = 0; n < 612; n++) begin
                if ($urandom_range(199) == 0)
                    send_word(OP_SEED, $urandom(), $urandom());
                else
                    send_word(OP_DRAW, $urandom(), pick_limit());
            end
        end
        go_idle();
        recv_idle = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (1300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("mt19937_random_generator_top: match");
        end else begin
            $display("mt19937_random_generator_top: mismatch");
        end
        $finish;
    end

    // watchdog, well above the slowest correct run
    initial begin
        #4000000;
        $display("mt19937_random_generator_top: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mtrg_pkg.sv
rtl/core/mtrg_if.sv
rtl/core/mtrg_front.sv
rtl/core/mtrg_queue.sv
rtl/core/mtrg_back.sv
rtl/core/mt19937_random_generator_top.sv
rtl/core/mtrg_checker.sv
dv/mt19937_random_generator_checker.sv
dv/tb.sv
